// File: sv/hri_pkg.sv
package hri_pkg;

    // Fixed widths of the channel fields and the configuration register.
    localparam int SEQ_INDEX_W = 31;
    localparam int FRACTION_W  = 32;
    localparam int RADIX_W     = 5;

    // One base-b digit is held per cell; a 5-bit radix bounds the digit value.
    localparam int DIGIT_W = RADIX_W;

    // Smallest radix that forms a valid base, and the radix after reset.
    localparam int RADIX_MIN   = 2;
    localparam int RADIX_RESET = 2;

    // Default values of the top level parameters.
    localparam int INDEX_BITS_DEF = 31;
    localparam int FRAC_BITS_DEF  = 32;

    // One doubling step travelling along the cell row: a step strobe and the
    // carry that the sending cell produced in that step.
    typedef struct packed {
        logic en;
        logic carry;
    } t_wave;

endpackage

// File: sv/hri_if.sv
interface hri_in_if
    import hri_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [SEQ_INDEX_W-1:0] seq_index;

    modport source (output valid, output seq_index, input ready);
    modport sink   (input valid, input seq_index, output ready);
endinterface

interface hri_out_if
    import hri_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [FRACTION_W-1:0] fraction;

    modport source (output valid, output fraction, input ready);
    modport sink   (input valid, input fraction, output ready);
endinterface

// File: sv/hri_cell.sv
// One base-b digit of the row. A step doubles the digit and adds the carry of
// the neighbor; a sum at or above the radix wraps and carries on. Steps come
// from the lower neighbor while the index is converted and from the upper
// neighbor while the fraction bits are drawn out.
module hri_cell
    import hri_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clr,
    input  logic [RADIX_W-1:0] i_radix,
    input  t_wave              i_up,
    input  t_wave              i_dn,
    output t_wave              o_up,
    output t_wave              o_dn
);

    logic [DIGIT_W-1:0] r_digit, n_digit;
    t_wave              r_up, n_up;
    t_wave              r_dn, n_dn;
    logic               w_carry_in;
    logic [DIGIT_W:0]   w_sum;
    logic [DIGIT_W:0]   w_wrap;
    logic               w_ge;

    assign w_carry_in = i_up.en ? i_up.carry : i_dn.carry;
    assign w_sum      = {r_digit, w_carry_in};
    assign w_ge       = (w_sum >= {1'b0, i_radix});
    assign w_wrap     = w_sum - {1'b0, i_radix};

    always_comb begin
        n_digit  = r_digit;
        n_up.en  = i_up.en & ~i_clr;
        n_up.carry = w_ge;
        n_dn.en  = i_dn.en & ~i_clr;
        n_dn.carry = w_ge;
        if (i_clr) begin
            n_digit = '0;
        end else if (i_up.en || i_dn.en) begin
            n_digit = w_ge ? w_wrap[DIGIT_W-1:0] : w_sum[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
        if (!i_rst_n) begin
            r_up <= '0;
            r_dn <= '0;
        end else begin
            r_up <= n_up;
            r_dn <= n_dn;
        end
    end

    assign o_up = r_up;
    assign o_dn = r_dn;

endmodule

// File: sv/halton_radical_inverse_top.sv
// Halton radical inverse: each transfer on i_item carries a sequence index, and
// one transfer on o_result returns its radical inverse in the base held in the
// radix register, as an exact truncated Q0.32 fraction. An index of zero, or a
// radix of zero or one, gives zero. The work runs on a row of INDEX_BITS digit
// cells. First the index bits are shifted in, most significant first, as a
// doubling wave that walks up the row and leaves the index written in base b,
// least significant digit in cell 0. Read from cell 0 upward, those digits are
// exactly the mirrored fraction 0.d0 d1 d2 ... in base b, so a second doubling
// wave walking down the row pushes one fraction bit per step out of cell 0.
// One item is in work at a time. The time from its transfer to the point
// where its result is ready for o_result is set by the two passes of the wave
// over the cell row and the FRAC_BITS fraction steps; the radix does not
// change it. The next index is taken as soon as the result sits in the output
// register, even while it waits there. The radix register may be written
// only while no item is in work.
module halton_radical_inverse_top
    import hri_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [RADIX_W-1:0] i_cfg_wdata,
    hri_in_if.sink             i_item,
    hri_out_if.source          o_result
);

    // Counters hold any step count of either pass.
    localparam int CNT_MAX = (INDEX_BITS > FRAC_BITS) ? INDEX_BITS : FRAC_BITS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    // Sequencer codes.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_FRAC  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [CNT_W-1:0]      r_got, n_got;
    logic [INDEX_BITS-1:0] r_idx, n_idx;
    logic [FRAC_BITS-1:0]  r_q, n_q;
    logic [RADIX_W-1:0]    r_radix;
    logic                  r_out_valid, n_out_valid;
    logic [FRACTION_W-1:0] r_fraction, n_fraction;

    logic                  w_accept;
    logic                  w_load_out;
    logic [63:0]           w_idx_wide;
    logic [63:0]           w_q_wide;

    // Wave taps between the cells: w_up[i] feeds cell i from below, w_dn[i+1]
    // feeds cell i from above. The controller drives the two row ends.
    t_wave                 w_up [INDEX_BITS+1];
    t_wave                 w_dn [INDEX_BITS+1];

    assign w_accept   = i_item.valid && i_item.ready;
    assign w_idx_wide = 64'(i_item.seq_index);
    assign w_q_wide   = 64'(r_q);

    // A new index is taken only when the row is free.
    assign i_item.ready = (r_state == S_IDLE);

    // The result moves to the output register once that register is free or
    // is being emptied in the same cycle.
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || o_result.ready);

    // Conversion wave: one index bit per cycle enters cell 0, highest bit first.
    assign w_up[0].en    = (r_state == S_CONV);
    assign w_up[0].carry = r_idx[INDEX_BITS-1];

    // Fraction wave: the top cell is doubled with a zero carry once per step.
    assign w_dn[INDEX_BITS].en    = (r_state == S_FRAC);
    assign w_dn[INDEX_BITS].carry = 1'b0;

    for (genvar g = 0; g < INDEX_BITS; g++) begin : g_cell
        hri_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clr   (w_accept),
            .i_radix (r_radix),
            .i_up    (w_up[g]),
            .i_dn    (w_dn[g+1]),
            .o_up    (w_up[g+1]),
            .o_dn    (w_dn[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_got       = r_got;
        n_idx       = r_idx;
        n_q         = r_q;
        n_out_valid = r_out_valid;
        n_fraction  = r_fraction;

        // Each carry leaving cell 0 in the fraction wave is the next bit of
        // the quotient, most significant first.
        if (w_dn[0].en) begin
            n_q   = {r_q[FRAC_BITS-2:0], w_dn[0].carry};
            n_got = r_got + CNT_W'(1);
        end

        if (o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_idx   = w_idx_wide[INDEX_BITS-1:0];
                    n_cnt   = '0;
                    n_got   = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_idx = {r_idx[INDEX_BITS-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(INDEX_BITS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                // Let the last conversion step reach the top cell.
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(INDEX_BITS - 2)) begin
                    n_cnt   = '0;
                    n_state = S_FRAC;
                end
            end
            S_FRAC: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(FRAC_BITS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_got == CNT_W'(FRAC_BITS)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_fraction  = (r_radix < RADIX_W'(RADIX_MIN)) ? '0
                                                                 : w_q_wide[FRACTION_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_q        <= n_q;
        r_fraction <= n_fraction;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_got       <= '0;
            r_out_valid <= 1'b0;
            r_radix     <= RADIX_W'(RADIX_RESET);
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_got       <= n_got;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_radix <= i_cfg_wdata;
            end
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.fraction = r_fraction;

`ifndef SYNTHESIS
    // In a valid base the index always fits in the digit row, so the top cell
    // never carries out. Radices zero and one leave the row meaningless.
    a_no_row_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_up[INDEX_BITS].en && (r_radix >= RADIX_W'(RADIX_MIN)))
            |-> !w_up[INDEX_BITS].carry)
        else $error("digit row overflowed during index conversion");

    // The fraction wave must not reach the top cell before the conversion wave
    // has left it.
    a_waves_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_up[INDEX_BITS-1].en && w_dn[INDEX_BITS].en))
        else $error("conversion and fraction waves met in the top cell");

    // No quotient bit may leave the row while no item is in work.
    a_no_stray_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_dn[0].en)
        else $error("quotient bit emitted while idle");

    // A base below two always gives a zero result.
    a_bad_radix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && (r_radix < RADIX_W'(RADIX_MIN))) |=> (o_result.fraction == '0))
        else $error("nonzero result for a radix below two");

    // Every quotient bit is collected before the result is offered.
    a_all_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |-> (r_got == CNT_W'(FRAC_BITS)))
        else $error("result loaded before all quotient bits arrived");
`endif

endmodule
